/* rtl/tcp_pkg.sv */
// Shared types, character constants and code tables for the 5-bit text code packer.
`default_nettype none

package tcp_pkg;

    localparam int CODE_BITS   = 5;
    localparam int PEND_DEPTH  = 5;
    localparam int ENT_LEN     = 6;
    localparam int PUNCT_LEN   = 16;
    localparam int QUEUE_DEPTH = 4;

    // Code values
    localparam logic [4:0] CODE_NUL    = 5'd0;
    localparam logic [4:0] CODE_ESC    = 5'd1;
    localparam logic [4:0] CODE_SPACE  = 5'd2;
    localparam logic [4:0] CODE_EOL    = 5'd3;
    localparam logic [4:0] CODE_BAR    = 5'd4;
    localparam logic [4:0] CODE_LETTER = 5'd5;
    localparam logic [4:0] CODE_PUNCT  = 5'd15;
    localparam logic [4:0] CODE_BSLASH = 5'd1;
    localparam logic [4:0] CODE_TAB    = 5'd2;

    // Byte values
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_Z_LOWER = 8'h7A;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_C2      = 8'hC2;
    localparam logic [7:0] CH_A0      = 8'hA0;

    // "&nbsp;" and "&#160;"
    localparam logic [7:0] ENT_NBSP [ENT_LEN] = '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B};
    localparam logic [7:0] ENT_NUM  [ENT_LEN] = '{8'h26, 8'h23, 8'h31, 8'h36, 8'h30, 8'h3B};

    // . , - _ / : ; ? ! @ * $ + = " '
    localparam logic [7:0] PUNCT [PUNCT_LEN] = '{
        8'h2E, 8'h2C, 8'h2D, 8'h5F, 8'h2F, 8'h3A, 8'h3B, 8'h3F,
        8'h21, 8'h40, 8'h2A, 8'h24, 8'h2B, 8'h3D, 8'h22, 8'h27
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } t_out_item;

    // One code on its way from the front to the packer; fin marks the terminator.
    typedef struct packed {
        logic [4:0] code;
        logic       fin;
    } t_code_tok;

    // Codes for one plain character: an escape first when two is set.
    typedef struct packed {
        logic       two;
        logic [4:0] code;
    } t_char_code;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_START,
        FE_CODE,
        FE_FLUSH,
        FE_FRESH,
        FE_TERM
    } t_fe_state;

    function automatic t_char_code char_code(input logic [7:0] c);
        t_char_code r;
        logic [7:0] t;
        logic       found;
        r.two  = 1'b0;
        r.code = CODE_NUL;
        t      = '0;
        found  = 1'b0;
        priority if (c >= CH_A_LOWER && c <= CH_Z_LOWER) begin
            t      = c - CH_A_LOWER + {3'd0, CODE_LETTER};
            r.code = t[4:0];
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            t      = c - CH_ZERO + {3'd0, CODE_LETTER};
            r.two  = 1'b1;
            r.code = t[4:0];
        end else if (c == CH_SPACE) begin
            r.code = CODE_SPACE;
        end else if (c == CH_LF || c == CH_CR) begin
            r.code = CODE_EOL;
        end else if (c == CH_BAR) begin
            r.code = CODE_BAR;
        end else if (c == CH_BSLASH) begin
            r.two  = 1'b1;
            r.code = CODE_BSLASH;
        end else if (c == CH_TAB) begin
            r.two  = 1'b1;
            r.code = CODE_TAB;
        end else begin
            for (int i = 0; i < PUNCT_LEN; i++) begin
                if (!found && c == PUNCT[i]) begin
                    found  = 1'b1;
                    r.two  = 1'b1;
                    t      = 8'(i) + {3'd0, CODE_PUNCT};
                    r.code = t[4:0];
                end
            end
        end
        return r;
    endfunction

    // Bytes that open a possible multi-byte pattern.
    function automatic logic opens_pattern(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR) || (c == CH_C2) || (c == CH_AMP);
    endfunction

endpackage

`default_nettype wire

/* rtl/tcp_front.sv */
// Front end: accepts text bytes, matches held patterns and issues 5-bit codes.
`default_nettype none

module tcp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire tcp_pkg::t_in_item i_in_item,
    output logic                   o_push,
    output tcp_pkg::t_code_tok     o_tok,
    input  wire logic              i_full
);
    import tcp_pkg::*;

    t_fe_state  r_state, n_state;
    t_fe_state  r_plan;
    t_fe_state  r_after;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_two;
    logic       r_sub;
    logic [2:0] r_idx;
    logic [2:0] r_count;
    logic [7:0] r_pend [PEND_DEPTH];
    logic       r_started;
    logic       r_stopped;

    logic       accept;
    logic [7:0] b;
    logic       lst;

    // classification of the incoming byte against what is held
    t_fe_state  d_target;
    t_fe_state  d_after;
    logic       d_two;
    logic       d_append;
    logic       d_clear;
    logic       m1;
    logic       m2;
    logic [7:0] ent1_k;
    logic [7:0] ent2_k;
    logic       first_eol;

    // per-state work
    t_char_code cc_f;
    t_char_code cc_b;
    logic       fresh_hold;
    logic       seg_done;
    logic       step_done;

    assign b          = i_in_item.in_byte;
    assign lst        = i_in_item.last_in;
    assign o_in_stall = (r_state != FE_IDLE);
    assign accept     = i_in_valid && (r_state == FE_IDLE);

    always_comb begin
        m1     = 1'b1;
        m2     = 1'b1;
        ent1_k = '0;
        ent2_k = '0;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            if (3'(i) < r_count) begin
                if (r_pend[i] != ENT_NBSP[i]) m1 = 1'b0;
                if (r_pend[i] != ENT_NUM[i])  m2 = 1'b0;
            end
        end
        for (int j = 0; j < ENT_LEN; j++) begin
            if (r_count == 3'(j)) begin
                ent1_k = ENT_NBSP[j];
                ent2_k = ENT_NUM[j];
            end
        end
        if (b != ent1_k) m1 = 1'b0;
        if (b != ent2_k) m2 = 1'b0;
    end

    assign first_eol = (r_pend[0] == CH_LF) || (r_pend[0] == CH_CR);

    always_comb begin
        d_target = FE_IDLE;
        d_after  = FE_TERM;
        d_two    = 1'b0;
        d_append = 1'b0;
        d_clear  = 1'b0;
        priority if (b == CH_NUL) begin
            d_target = (r_count != 3'd0) ? FE_FLUSH : FE_TERM;
        end else if (r_count == 3'd0) begin
            d_target = FE_FRESH;
        end else if (first_eol) begin
            if ((r_pend[0] == CH_LF && b == CH_CR) || (r_pend[0] == CH_CR && b == CH_LF)) begin
                d_target = FE_CODE;
                d_clear  = 1'b1;
            end else begin
                d_target = FE_FLUSH;
                d_after  = FE_FRESH;
            end
        end else if (r_pend[0] == CH_C2) begin
            if (b == CH_A0) begin
                d_target = FE_CODE;
                d_two    = 1'b1;
                d_clear  = 1'b1;
            end else begin
                d_target = FE_FLUSH;
                d_after  = FE_FRESH;
            end
        end else if (m1 || m2) begin
            if (r_count == 3'(PEND_DEPTH)) begin
                d_target = FE_CODE;
                d_two    = 1'b1;
                d_clear  = 1'b1;
            end else begin
                // keep collecting the entity; a last byte flushes what is held
                d_append = 1'b1;
                d_target = lst ? FE_FLUSH : FE_IDLE;
            end
        end else begin
            d_target = FE_FLUSH;
            d_after  = FE_FRESH;
        end
    end

    assign cc_f       = char_code(r_pend[r_idx]);
    assign cc_b       = char_code(r_byte);
    assign fresh_hold = opens_pattern(r_byte);

    // outputs of each state
    always_comb begin
        o_push     = 1'b0;
        o_tok.code = CODE_NUL;
        o_tok.fin  = 1'b0;
        seg_done   = 1'b0;
        step_done  = 1'b0;
        unique case (r_state)
            FE_IDLE: begin
            end
            FE_START: begin
                o_tok.code = r_sub ? CODE_NUL : CODE_ESC;
                o_push     = !i_full;
                seg_done   = r_sub && !i_full;
                step_done  = seg_done;
            end
            FE_CODE: begin
                o_tok.code = (r_two && !r_sub) ? CODE_ESC : CODE_EOL;
                o_push     = !i_full;
                seg_done   = (!r_two || r_sub) && !i_full;
                step_done  = seg_done;
            end
            FE_FLUSH: begin
                o_tok.code = (cc_f.two && !r_sub) ? CODE_ESC : cc_f.code;
                o_push     = !i_full;
                seg_done   = (!cc_f.two || r_sub) && !i_full;
                step_done  = seg_done && (r_idx == r_count - 3'd1);
            end
            FE_FRESH: begin
                if (fresh_hold) begin
                    step_done = 1'b1;
                end else begin
                    o_tok.code = (cc_b.two && !r_sub) ? CODE_ESC : cc_b.code;
                    o_push     = !i_full;
                    seg_done   = (!cc_b.two || r_sub) && !i_full;
                    step_done  = seg_done;
                end
            end
            FE_TERM: begin
                o_tok.fin = 1'b1;
                o_push    = !i_full;
                seg_done  = !i_full;
                step_done = seg_done;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FE_IDLE: begin
                if (accept && !r_stopped) n_state = r_started ? d_target : FE_START;
            end
            FE_START: begin
                if (step_done) n_state = r_plan;
            end
            FE_CODE: begin
                if (step_done) n_state = r_last ? FE_TERM : FE_IDLE;
            end
            FE_FLUSH: begin
                if (step_done) n_state = r_after;
            end
            FE_FRESH: begin
                if (step_done) begin
                    if (r_last) n_state = fresh_hold ? FE_FLUSH : FE_TERM;
                    else        n_state = FE_IDLE;
                end
            end
            FE_TERM: begin
                if (step_done) n_state = FE_IDLE;
            end
            default: n_state = FE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FE_IDLE;
            r_plan    <= FE_IDLE;
            r_after   <= FE_TERM;
            r_two     <= 1'b0;
            r_last    <= 1'b0;
            r_sub     <= 1'b0;
            r_idx     <= '0;
            r_count   <= '0;
            r_started <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            r_state <= n_state;
            if (seg_done)    r_sub <= 1'b0;
            else if (o_push) r_sub <= 1'b1;

            if (accept) begin
                if (r_stopped) begin
                    // drop bytes until the end of the string
                    if (lst) begin
                        r_stopped <= 1'b0;
                        r_started <= 1'b0;
                    end
                end else begin
                    r_last    <= lst;
                    r_two     <= d_two;
                    r_plan    <= d_target;
                    r_after   <= d_after;
                    r_sub     <= 1'b0;
                    r_idx     <= '0;
                    r_started <= !lst;
                    r_stopped <= (b == CH_NUL) && !lst;
                    if (d_clear)  r_count <= '0;
                    if (d_append) r_count <= r_count + 3'd1;
                end
            end

            if (r_state == FE_FLUSH && seg_done) begin
                if (step_done) begin
                    r_idx   <= '0;
                    r_count <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end

            if (r_state == FE_FRESH && fresh_hold) begin
                r_count <= 3'd1;
                r_after <= FE_TERM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_stopped) r_byte <= b;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            if (accept && !r_stopped && d_append && r_count == 3'(i)) r_pend[i] <= b;
        end
        if (r_state == FE_FRESH && fresh_hold) r_pend[0] <= r_byte;
    end

endmodule

`default_nettype wire

/* rtl/tcp_fifo.sv */
// Short code queue between the front end and the bit packer.
`default_nettype none

module tcp_fifo #(
    parameter int DEPTH = tcp_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tcp_pkg::t_code_tok i_tok,
    output logic                    o_full,
    input  wire logic               i_pop,
    output tcp_pkg::t_code_tok      o_tok,
    output logic                    o_empty
);
    import tcp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_code_tok   r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_tok   = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        if (do_pop)  n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_tok;
    end

endmodule

`default_nettype wire

/* rtl/tcp_back.sv */
// Back end: packs 5-bit codes MSB first into bytes and pads the end of a string.
`default_nettype none

module tcp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    output logic                    o_pop,
    input  wire tcp_pkg::t_code_tok i_tok,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tcp_pkg::t_out_item      o_out_item
);
    import tcp_pkg::*;

    logic [6:0]  r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_ov, n_ov;
    logic        r_pad_v, n_pad_v;
    logic [7:0]  r_ob, n_ob;
    logic        r_ol, n_ol;
    logic [7:0]  r_pad, n_pad;

    logic        slot;
    logic [11:0] a;
    logic [3:0]  n;
    logic        emit;
    logic [3:0]  sh0;
    logic [11:0] shr;
    logic [7:0]  byte0;
    logic [2:0]  n2;
    logic [6:0]  rem;
    logic [3:0]  shp;
    logic [14:0] padw;
    logic [7:0]  pad;

    assign slot  = !r_ov || !i_out_stall;
    assign o_pop = slot && !r_pad_v && !i_empty;

    assign a     = {r_acc, i_tok.code};
    assign n     = {1'b0, r_cnt} + 4'(CODE_BITS);
    assign emit  = (n >= 4'd8);
    assign sh0   = n - 4'd8;
    assign shr   = a >> sh0[2:0];
    assign byte0 = shr[7:0];
    assign n2    = emit ? sh0[2:0] : n[2:0];
    assign rem   = a[6:0] & (7'h7F >> (3'd7 - n2));
    assign shp   = 4'd8 - {1'b0, n2};
    assign padw  = {8'd0, rem} << shp;
    assign pad   = padw[7:0];

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_ov    = r_ov;
        n_pad_v = r_pad_v;
        n_ob    = r_ob;
        n_ol    = r_ol;
        n_pad   = r_pad;
        if (slot) begin
            n_ov = 1'b0;
            if (r_pad_v) begin
                n_ob    = r_pad;
                n_ol    = 1'b1;
                n_ov    = 1'b1;
                n_pad_v = 1'b0;
            end else if (o_pop) begin
                if (i_tok.fin) begin
                    n_acc = '0;
                    n_cnt = '0;
                end else begin
                    n_acc = rem;
                    n_cnt = n2;
                end
                if (emit) begin
                    n_ob = byte0;
                    n_ol = i_tok.fin && (n2 == 3'd0);
                    n_ov = 1'b1;
                    // hold the padded tail until the byte before it has been taken
                    if (i_tok.fin && n2 != 3'd0) begin
                        n_pad   = pad;
                        n_pad_v = 1'b1;
                    end
                end else if (i_tok.fin) begin
                    n_ob = pad;
                    n_ol = 1'b1;
                    n_ov = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_pad_v <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_pad_v <= n_pad_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob  <= n_ob;
        r_ol  <= n_ol;
        r_pad <= n_pad;
    end

    assign o_out_valid         = r_ov;
    assign o_out_item.out_byte = r_ob;
    assign o_out_item.last_out = r_ol;

endmodule

`default_nettype wire

/* rtl/text_5bit_code_packer_top.sv */
// Top level of the 5-bit text code packer: front end, code queue and bit packer.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one text byte per item,
// with last_in on the final byte of a string. Output channel (o_out_valid /
// i_out_stall / o_out_item) delivers packed bytes, 5-bit codes MSB first, with
// last_out on the final, zero-padded byte of each string.
// The front end issues one code per cycle into a short queue unless it is full,
// and takes no new byte until it has issued every code for the last: one for a
// letter, space or line end, two for an escaped character, two more for the starter
// at the head of a string, those of each held byte when a pattern match fails, and
// one for the terminator. A byte that extends a pending pattern issues no code.
// The packer takes one code per cycle unless the output stalls; a packed byte
// appears the cycle after its last code, the zero-padded tail once that is taken.
// Reset clears the queue, the pending pattern, the bit accumulator and the string
// flags; the first byte after reset starts a new string.
// When the receiver stalls, the output item holds, the packer stops draining the
// queue, and once the queue fills the front end holds o_in_stall high.
`default_nettype none

module text_5bit_code_packer_top #(
    parameter int QUEUE_DEPTH = tcp_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tcp_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tcp_pkg::t_out_item      o_out_item
);
    import tcp_pkg::*;

    logic      q_push;
    t_code_tok q_tok_in;
    logic      q_full;
    logic      q_pop;
    t_code_tok q_tok_out;
    logic      q_empty;

    tcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (q_push),
        .o_tok      (q_tok_in),
        .i_full     (q_full)
    );

    tcp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (q_tok_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_tok   (q_tok_out),
        .o_empty (q_empty)
    );

    tcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .i_tok       (q_tok_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("code pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("code popped from an empty queue");

    a_term_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && q_tok_in.fin) |=> !o_in_stall)
        else $error("front end not ready after issuing the terminator");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 5-bit text code packer, with a built-in encoder mirror.
module tb_top;
    import tcp_pkg::*;

    logic      clk;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item  = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Encoder mirror state
    logic [7:0]  held_bytes [PEND_DEPTH];
    int unsigned held_n    = 0;
    logic [6:0]  bit_acc   = '0;
    int unsigned bit_n     = 0;
    bit          in_string = 1'b0;
    bit          halted    = 1'b0;
    int unsigned bytes_this_item;
    t_out_item   packed_q [$];

    int unsigned mismatch_cnt = 0;
    int unsigned text_items   = 0;
    bit          steady_in    = 1'b0;

    text_5bit_code_packer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void put_code(input logic [4:0] code);
        logic [11:0] acc_wide;
        int unsigned n;
        t_out_item   ob;
        acc_wide = {bit_acc, code};
        n        = bit_n + 5;
        if (n >= 8) begin
            ob.out_byte = 8'(acc_wide >> (n - 8));
            ob.last_out = 1'b0;
            packed_q.push_back(ob);
            bytes_this_item++;
            n -= 8;
        end
        bit_acc = 7'(acc_wide & ((12'd1 << n) - 12'd1));
        bit_n   = n;
    endfunction

    function automatic void put_char(input logic [7:0] c);
        int idx;
        idx = -1;
        if (c >= CH_A_LOWER && c <= CH_Z_LOWER) begin
            put_code(CODE_LETTER + 5'(c - CH_A_LOWER));
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            put_code(CODE_ESC);
            put_code(CODE_LETTER + 5'(c - CH_ZERO));
        end else if (c == CH_SPACE) begin
            put_code(CODE_SPACE);
        end else if (c == CH_LF || c == CH_CR) begin
            put_code(CODE_EOL);
        end else if (c == CH_BAR) begin
            put_code(CODE_BAR);
        end else if (c == CH_BSLASH) begin
            put_code(CODE_ESC);
            put_code(CODE_BSLASH);
        end else if (c == CH_TAB) begin
            put_code(CODE_ESC);
            put_code(CODE_TAB);
        end else begin
            for (int i = 0; i < PUNCT_LEN; i++) begin
                if (idx < 0 && PUNCT[i] == c) idx = i;
            end
            if (idx >= 0) begin
                put_code(CODE_ESC);
                put_code(CODE_PUNCT + 5'(idx));
            end else begin
                put_code(CODE_NUL);
            end
        end
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_n; i++) put_char(held_bytes[i]);
        held_n = 0;
    endfunction

    function automatic void start_fresh(input logic [7:0] b);
        if (b == CH_LF || b == CH_CR || b == CH_C2 || b == CH_AMP) begin
            held_bytes[0] = b;
            held_n        = 1;
        end else begin
            put_char(b);
        end
    endfunction

    function automatic void step_held(input logic [7:0] b);
        logic [7:0] first;
        bit         nbsp_ok;
        bit         num_ok;
        if (held_n == 0) begin
            start_fresh(b);
            return;
        end
        first = held_bytes[0];
        if (first == CH_LF || first == CH_CR) begin
            if ((first == CH_LF && b == CH_CR) || (first == CH_CR && b == CH_LF)) begin
                put_code(CODE_EOL);
                held_n = 0;
                return;
            end
        end else if (first == CH_C2) begin
            if (b == CH_A0) begin
                put_code(CODE_ESC);
                put_code(CODE_EOL);
                held_n = 0;
                return;
            end
        end else begin
            nbsp_ok = 1'b1;
            num_ok  = 1'b1;
            for (int i = 0; i < held_n; i++) begin
                if (held_bytes[i] != ENT_NBSP[i]) nbsp_ok = 1'b0;
                if (held_bytes[i] != ENT_NUM[i]) num_ok = 1'b0;
            end
            if (b != ENT_NBSP[held_n]) nbsp_ok = 1'b0;
            if (b != ENT_NUM[held_n]) num_ok = 1'b0;
            if (nbsp_ok || num_ok) begin
                if (held_n + 1 == ENT_LEN) begin
                    put_code(CODE_ESC);
                    put_code(CODE_EOL);
                    held_n = 0;
                end else begin
                    held_bytes[held_n] = b;
                    held_n++;
                end
                return;
            end
        end
        // no match: spill what is held, then treat the new byte on its own
        flush_held();
        start_fresh(b);
    endfunction

    function automatic void finish_string();
        t_out_item ob;
        flush_held();
        put_code(CODE_NUL);
        if (bit_n > 0) begin
            ob.out_byte = 8'({1'b0, bit_acc} << (8 - bit_n));
            ob.last_out = 1'b0;
            packed_q.push_back(ob);
            bytes_this_item++;
        end
        bit_acc = '0;
        bit_n   = 0;
        if (bytes_this_item > 0) packed_q[packed_q.size() - 1].last_out = 1'b1;
    endfunction

    function automatic void encode_item(input logic [7:0] b, input logic is_last);
        bytes_this_item = 0;
        if (halted) begin
            // drop everything after a null until the end of the string
            if (is_last) begin
                halted    = 1'b0;
                in_string = 1'b0;
            end
            return;
        end
        text_items++;
        if (!in_string) begin
            put_code(CODE_ESC);
            put_code(CODE_NUL);
            in_string = 1'b1;
        end
        if (b == CH_NUL) begin
            finish_string();
            if (is_last) in_string = 1'b0;
            else halted = 1'b1;
            return;
        end
        step_held(b);
        if (is_last) begin
            finish_string();
            in_string = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        if (mismatch_cnt < 10) $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_cnt++;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive one item at the falling edge, hold it until accepted.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: b, last_in: is_last};
        do @(posedge clk); while (in_stall);
        encode_item(b, is_last);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (packed_q.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic test_zero_first();
        send_byte(CH_NUL, 1'b0);
        send_byte("q", 1'b0);
        send_byte("r", 1'b1);
    endtask

    task automatic test_char_classes();
        send_text("az |\t\\0'\377");
        wait_drained();
    endtask

    task automatic test_patterns();
        send_text("\015\n\n\015\302\240&nbsp;");
    endtask

    task automatic test_broken_patterns();
        send_text("&#16x\302");
    endtask

    task automatic send_random_string();
        logic [7:0]  txt [$];
        int unsigned target;
        int unsigned kind;
        int unsigned cut;
        int unsigned r;
        bit          use_num;
        target = $urandom_range(1, 14);
        while (txt.size() < target) begin
            kind = $urandom_range(0, 19);
            case (kind)
                5: txt.push_back(CH_SPACE);
                6: txt.push_back(CH_BAR);
                7: txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                8: txt.push_back(PUNCT[$urandom_range(0, PUNCT_LEN - 1)]);
                9: txt.push_back($urandom_range(0, 1) ? CH_TAB : CH_BSLASH);
                10: begin
                    txt.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                    txt.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                end
                11: begin
                    txt.push_back(CH_C2);
                    txt.push_back($urandom_range(0, 2) ? CH_A0 : 8'($urandom_range(0, 255)));
                end
                12, 13: begin
                    use_num = $urandom_range(0, 1);
                    for (int i = 0; i < ENT_LEN; i++)
                        txt.push_back(use_num ? ENT_NUM[i] : ENT_NBSP[i]);
                end
                14: begin
                    use_num = $urandom_range(0, 1);
                    cut     = $urandom_range(1, ENT_LEN - 1);
                    for (int i = 0; i < cut; i++)
                        txt.push_back(use_num ? ENT_NUM[i] : ENT_NBSP[i]);
                end
                15, 16: txt.push_back(8'($urandom_range(0, 255)));
                17: txt.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                default: txt.push_back(CH_A_LOWER + 8'($urandom_range(0, 25)));
            endcase
        end
        // occasionally place a null in the string, which ends it there
        r = $urandom_range(0, 99);
        if (r < 8 && txt.size() > 1) txt[$urandom_range(0, txt.size() - 2)] = CH_NUL;
        else if (r < 11) txt[txt.size() - 1] = CH_NUL;
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic test_random_text();
        int unsigned goal;
        int unsigned strings;
        goal    = text_items + 500;
        strings = 0;
        while (text_items < goal) begin
            steady_in = ($urandom_range(0, 9) == 0);
            send_random_string();
            strings++;
            if (strings == 20) wait_drained();
        end
        steady_in = 1'b0;
    endtask

    initial begin : out_stall_gen
        int unsigned r;
        int unsigned span;
        bit          hold;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                hold = 1'b0;
                span = $urandom_range(40, 150);
            end else if (r < 65) begin
                hold = 1'b0;
                span = $urandom_range(1, 6);
            end else if (r < 95) begin
                hold = 1'b1;
                span = $urandom_range(1, 3);
            end else begin
                hold = 1'b1;
                span = $urandom_range(10, 40);
            end
            out_stall <= hold;
            repeat (span) @(negedge clk);
        end
    end

    always @(posedge clk) begin : check_out
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (packed_q.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %h last %b",
                                        out_item.out_byte, out_item.last_out));
            end else begin
                want = packed_q.pop_front();
                if (out_item.out_byte !== want.out_byte)
                    note_mismatch($sformatf("out_byte expected %h got %h",
                                            want.out_byte, out_item.out_byte));
                if (out_item.last_out !== want.last_out)
                    note_mismatch($sformatf("last_out expected %b got %b",
                                            want.last_out, out_item.last_out));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_zero_first();
        test_char_classes();
        test_patterns();
        test_broken_patterns();
        test_random_text();
        in_valid <= 1'b0;
        while (packed_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && packed_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
